/* hdl/hsvg_pkg.sv */
// Shared types, constants and a helper function for the HSV saturation/value gain block.
package hsvg_pkg;

	localparam int COMP_W = 8;
	localparam int GAIN_W = 9;
	localparam int DATA_W = 3 * COMP_W;
	localparam int ADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int NUM_STAGES = 11;

	localparam logic [GAIN_W-1:0] GAIN_UNITY = 9'd100;

	localparam logic REG_SAT_GAIN = 1'b0;
	localparam logic REG_VAL_GAIN = 1'b1;

	localparam logic [17:0] DIV100_MUL = 18'd167773;
	localparam logic [10:0] DIV60_MUL = 11'd1093;
	localparam logic [12:0] DIV15_MUL = 13'd4370;

	localparam logic [8:0] HUE_FULL = 9'd360;
	localparam logic [8:0] HUE_GREEN = 9'd120;
	localparam logic [8:0] HUE_BLUE = 9'd240;

	localparam logic [2:0] SECT_0 = 3'd0;
	localparam logic [2:0] SECT_1 = 3'd1;
	localparam logic [2:0] SECT_2 = 3'd2;
	localparam logic [2:0] SECT_3 = 3'd3;
	localparam logic [2:0] SECT_4 = 3'd4;
	localparam logic [2:0] SECT_5 = 3'd5;

	typedef enum logic [1:0] {
		MAX_R = 2'd0,
		MAX_G = 2'd1,
		MAX_B = 2'd2
	} maxsel_t;

	typedef struct packed {
		logic [15:0] sat_num;
		logic [7:0]  sat_rem;
		logic [7:0]  sat_q;
		logic [7:0]  mx;
		logic [13:0] hue_num;
		logic [7:0]  hue_rem;
		logic [5:0]  hue_q;
		logic [7:0]  d;
		logic        neg;
		maxsel_t     msel;
	} dctx_t;

	typedef struct packed {
		logic              byp;
		logic [DATA_W-1:0] rgb;
	} pass_t;

	typedef struct packed {
		logic [7:0] rem;
		logic       qb;
	} dstep_t;

	function automatic dstep_t dstep(input logic [7:0] rem, input logic bin,
			input logic [7:0] dv);
		logic [8:0] t;
		dstep_t r;
		t = {rem, bin};
		if (t >= {1'b0, dv}) begin
			r.rem = 8'(t - {1'b0, dv});
			r.qb = 1'b1;
		end else begin
			r.rem = t[7:0];
			r.qb = 1'b0;
		end
		return r;
	endfunction

endpackage

/* hdl/hsv_saturation_value_gain_top.sv */
// Each accepted input word reaches the output through the registers of stages 1 to 11 in order.
// Throughput: one word per cycle; each stage stalls only when the stage after it is full.
// The two divisions run as restoring dividers, two quotient bits per stage, over stages 2 to 5 (hue: 2 to 4).
// Reset clears all stage valid bits and sets both gain registers to 100 percent.
// Top level: pipelined RGB to HSV, saturation and value gain, HSV to RGB.
module hsv_saturation_value_gain_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hsvg_pkg::ADDR_W-1:0]   paddr,
	input  logic [hsvg_pkg::PDATA_W-1:0]  pwdata,
	output logic [hsvg_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [hsvg_pkg::DATA_W-1:0]   s_axis_tdata,   // red_in, green_in, blue_in
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [hsvg_pkg::DATA_W-1:0]   m_axis_tdata    // red_out, green_out, blue_out
);
	import hsvg_pkg::*;

	logic [GAIN_W-1:0] sat_gain_q;
	logic [GAIN_W-1:0] val_gain_q;
	logic              cfg_wr;

	logic [NUM_STAGES:1] vld_s;
	logic [NUM_STAGES:1] adv;

	dctx_t dctx_s [1:5];
	pass_t pass_s [1:10];

	logic [8:0]  h_s6;
	logic [16:0] sprod_s6;
	logic [16:0] vprod_s6;

	logic [7:0]  sat_s7;
	logic [7:0]  val_s7;
	logic [8:0]  h_s7;
	logic [2:0]  sect_s7;

	logic [7:0]  sat_s8;
	logic [7:0]  val_s8;
	logic [2:0]  sect_s8;
	logic [7:0]  rem_s8;
	logic [7:0]  p_s8;

	logic [7:0]  sr_s9;
	logic [7:0]  st_s9;
	logic [7:0]  val_s9;
	logic [7:0]  p_s9;
	logic [2:0]  sect_s9;
	logic        satz_s9;

	logic [7:0]  q_s10;
	logic [7:0]  t_s10;
	logic [7:0]  val_s10;
	logic [7:0]  p_s10;
	logic [2:0]  sect_s10;
	logic        satz_s10;

	logic [DATA_W-1:0] out_s11;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_gain_q <= GAIN_UNITY;
			val_gain_q <= GAIN_UNITY;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SAT_GAIN: sat_gain_q <= pwdata[GAIN_W-1:0];
				default:      val_gain_q <= pwdata[GAIN_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SAT_GAIN: prdata = {{(PDATA_W-GAIN_W){1'b0}}, sat_gain_q};
			default:      prdata = {{(PDATA_W-GAIN_W){1'b0}}, val_gain_q};
		endcase
	end

	// stage handshake
	always_comb begin
		adv[NUM_STAGES] = !vld_s[NUM_STAGES] || m_axis_tready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign s_axis_tready = adv[1];
	assign m_axis_tvalid = vld_s[NUM_STAGES];
	assign m_axis_tdata = out_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) begin
				vld_s[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// stage 1: max, min, delta, saturation and hue numerators
	logic [7:0]  r_in, g_in, b_in;
	logic [7:0]  mx_c, mn_c, d_c, absd_c;
	logic        neg_c;
	maxsel_t     msel_c;
	dctx_t       dctx_c;
	pass_t       pass_c;

	assign r_in = s_axis_tdata[7:0];
	assign g_in = s_axis_tdata[15:8];
	assign b_in = s_axis_tdata[23:16];

	always_comb begin
		if (r_in >= g_in && r_in >= b_in) begin
			msel_c = MAX_R;
			mx_c = r_in;
			neg_c = g_in < b_in;
			absd_c = neg_c ? 8'(b_in - g_in) : 8'(g_in - b_in);
		end else if (g_in >= b_in) begin
			msel_c = MAX_G;
			mx_c = g_in;
			neg_c = b_in < r_in;
			absd_c = neg_c ? 8'(r_in - b_in) : 8'(b_in - r_in);
		end else begin
			msel_c = MAX_B;
			mx_c = b_in;
			neg_c = r_in < g_in;
			absd_c = neg_c ? 8'(g_in - r_in) : 8'(r_in - g_in);
		end
		mn_c = (r_in <= g_in) ? ((r_in <= b_in) ? r_in : b_in)
			: ((g_in <= b_in) ? g_in : b_in);
		d_c = 8'(mx_c - mn_c);

		dctx_c.sat_num = {d_c, 8'd0} - {8'd0, d_c};
		dctx_c.sat_rem = dctx_c.sat_num[15:8];
		dctx_c.sat_q = '0;
		dctx_c.mx = mx_c;
		dctx_c.hue_num = {absd_c, 6'd0} - {4'd0, absd_c, 2'd0};
		dctx_c.hue_rem = dctx_c.hue_num[13:6];
		dctx_c.hue_q = '0;
		dctx_c.d = d_c;
		dctx_c.neg = neg_c;
		dctx_c.msel = msel_c;

		pass_c.byp = (sat_gain_q == GAIN_UNITY) && (val_gain_q == GAIN_UNITY);
		pass_c.rgb = s_axis_tdata;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			dctx_s[1] <= dctx_c;
			pass_s[1] <= pass_c;
		end
	end

	// stages 2 to 5: two quotient bits per stage (hue quotient only in stages 2 to 4)
	for (genvar k = 2; k <= 5; k++) begin : g_div
		localparam int SHI = 11 - 2 * k;
		localparam int SLO = 10 - 2 * k;
		localparam int HHI = (k <= 4) ? 9 - 2 * k : 0;
		localparam int HLO = (k <= 4) ? 8 - 2 * k : 0;

		dctx_t  nxt;
		dstep_t sa, sb, ha, hb;

		always_comb begin
			nxt = dctx_s[k-1];
			sa = dstep(nxt.sat_rem, nxt.sat_num[SHI], nxt.mx);
			sb = dstep(sa.rem, nxt.sat_num[SLO], nxt.mx);
			nxt.sat_rem = sb.rem;
			nxt.sat_q[SHI] = sa.qb;
			nxt.sat_q[SLO] = sb.qb;
			ha = dstep(nxt.hue_rem, nxt.hue_num[HHI], nxt.d);
			hb = dstep(ha.rem, nxt.hue_num[HLO], nxt.d);
			if (k <= 4) begin
				nxt.hue_rem = hb.rem;
				nxt.hue_q[HHI] = ha.qb;
				nxt.hue_q[HLO] = hb.qb;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				dctx_s[k] <= nxt;
				pass_s[k] <= pass_s[k-1];
			end
		end
	end

	// stage 6: hue and gain products
	logic [8:0] hq_c;
	logic [8:0] h_c;
	logic [7:0] satr_c;
	logic       gray_c;

	always_comb begin
		gray_c = dctx_s[5].d == 8'd0;
		hq_c = {3'd0, dctx_s[5].hue_q};
		case (dctx_s[5].msel)
			MAX_R: begin
				if (!dctx_s[5].neg || hq_c == 9'd0) begin
					h_c = dctx_s[5].neg ? 9'd0 : hq_c;
				end else begin
					h_c = HUE_FULL - hq_c;
				end
			end
			MAX_G: h_c = dctx_s[5].neg ? HUE_GREEN - hq_c : HUE_GREEN + hq_c;
			default: h_c = dctx_s[5].neg ? HUE_BLUE - hq_c : HUE_BLUE + hq_c;
		endcase
		if (gray_c) begin
			h_c = 9'd0;
		end
		satr_c = gray_c ? 8'd0 : dctx_s[5].sat_q;
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			h_s6 <= h_c;
			sprod_s6 <= 17'(satr_c) * 17'(sat_gain_q);
			vprod_s6 <= 17'(dctx_s[5].mx) * 17'(val_gain_q);
			pass_s[6] <= pass_s[5];
		end
	end

	// stage 7: divide by 100 and clamp, hue sector
	logic [34:0] sdiv_c, vdiv_c;
	logic [19:0] hsec_c;

	always_comb begin
		sdiv_c = 35'(sprod_s6) * 35'(DIV100_MUL);
		vdiv_c = 35'(vprod_s6) * 35'(DIV100_MUL);
		hsec_c = 20'(h_s6) * 20'(DIV60_MUL);
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			sat_s7 <= (sdiv_c[34:24] > 11'd255) ? 8'd255 : sdiv_c[31:24];
			val_s7 <= (vdiv_c[34:24] > 11'd255) ? 8'd255 : vdiv_c[31:24];
			h_s7 <= h_s6;
			sect_s7 <= hsec_c[18:16];
			pass_s[7] <= pass_s[6];
		end
	end

	// stage 8: fraction within the sector, p
	logic [8:0]  base_c;
	logic [5:0]  m_c;
	logic [24:0] rprod_c;
	logic [15:0] pprod_c;

	always_comb begin
		base_c = {sect_s7, 6'd0} - {4'd0, sect_s7, 2'd0};
		m_c = 6'(h_s7 - base_c);
		rprod_c = 25'({m_c, 6'd0}) * 25'(DIV15_MUL);
		pprod_c = 16'(val_s7) * 16'(8'd255 - sat_s7);
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			sat_s8 <= sat_s7;
			val_s8 <= val_s7;
			sect_s8 <= sect_s7;
			rem_s8 <= rprod_c[23:16];
			p_s8 <= pprod_c[15:8];
			pass_s[8] <= pass_s[7];
		end
	end

	// stage 9: saturation times fraction
	logic [15:0] srprod_c, stprod_c;

	always_comb begin
		srprod_c = 16'(sat_s8) * 16'(rem_s8);
		stprod_c = 16'(sat_s8) * 16'(8'd255 - rem_s8);
	end

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			sr_s9 <= srprod_c[15:8];
			st_s9 <= stprod_c[15:8];
			val_s9 <= val_s8;
			p_s9 <= p_s8;
			sect_s9 <= sect_s8;
			satz_s9 <= sat_s8 == 8'd0;
			pass_s[9] <= pass_s[8];
		end
	end

	// stage 10: q and t
	logic [15:0] qprod_c, tprod_c;

	always_comb begin
		qprod_c = 16'(val_s9) * 16'(8'd255 - sr_s9);
		tprod_c = 16'(val_s9) * 16'(8'd255 - st_s9);
	end

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			q_s10 <= qprod_c[15:8];
			t_s10 <= tprod_c[15:8];
			val_s10 <= val_s9;
			p_s10 <= p_s9;
			sect_s10 <= sect_s9;
			satz_s10 <= satz_s9;
			pass_s[10] <= pass_s[9];
		end
	end

	// stage 11: sector select into the output register
	logic [DATA_W-1:0] rgb_c;

	always_comb begin
		case (sect_s10)
			SECT_0:  rgb_c = {p_s10, t_s10, val_s10};
			SECT_1:  rgb_c = {p_s10, val_s10, q_s10};
			SECT_2:  rgb_c = {t_s10, val_s10, p_s10};
			SECT_3:  rgb_c = {val_s10, q_s10, p_s10};
			SECT_4:  rgb_c = {val_s10, p_s10, t_s10};
			default: rgb_c = {q_s10, p_s10, val_s10};
		endcase
		if (satz_s10) begin
			rgb_c = {val_s10, val_s10, val_s10};
		end
		if (pass_s[10].byp) begin
			rgb_c = pass_s[10].rgb;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			out_s11 <= rgb_c;
		end
	end

`ifndef SYNTHESIS
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[NUM_STAGES] |-> s_axis_tready)
		else $error("input stalled with an empty output stage");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[6] |-> h_s6 < HUE_FULL)
		else $error("hue out of range");

	a_gray_sat: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[5] && dctx_s[5].d == 8'd0 && adv[6] |=> sprod_s6 == 17'd0)
		else $error("gray input produced nonzero saturation");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[7] |-> sect_s7 <= SECT_5)
		else $error("hue sector out of range");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[8] |-> rem_s8 <= 8'd251)
		else $error("sector fraction out of range");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the HSV saturation and value gain stream block.
`timescale 1ns / 1ps

module tb_top;
	import hsvg_pkg::*;

	localparam int PHASE_COUNT = 10;
	localparam int PHASE_ITEMS = 125;
	localparam int RX_HOLD_CYCLES = 150;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [ADDR_W-1:0] SAT_GAIN_ADDR = ADDR_W'({REG_SAT_GAIN, 2'b00});
	localparam logic [ADDR_W-1:0] VAL_GAIN_ADDR = ADDR_W'({REG_VAL_GAIN, 2'b00});

	typedef struct packed {
		logic [COMP_W-1:0] blue;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] red;
	} rgb_t;

	typedef struct packed {
		logic [GAIN_W-1:0] sat_gain;
		logic [GAIN_W-1:0] val_gain;
		rgb_t              px;
		logic              known;
		rgb_t              want;
	} vector_t;

	typedef struct {
		rgb_t px;
		rgb_t want;
	} pending_t;

	// colors as 24'hBBGGRR
	localparam int VECTOR_COUNT = 22;
	localparam vector_t DIRECTED_VECTORS [VECTOR_COUNT] = '{
		'{9'd100, 9'd100, 24'h000000, 1'b1, 24'h000000},
		'{9'd100, 9'd100, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
		'{9'd100, 9'd100, 24'h4DC80C, 1'b1, 24'h4DC80C},
		'{9'd0,   9'd100, 24'h0000FF, 1'b1, 24'hFFFFFF},
		'{9'd0,   9'd100, 24'h1EC80A, 1'b1, 24'hC8C8C8},
		'{9'd100, 9'd0,   24'h0000FF, 1'b1, 24'h000000},
		'{9'd200, 9'd200, 24'h000000, 1'b1, 24'h000000},
		'{9'd200, 9'd200, 24'h808080, 1'b1, 24'hFFFFFF},
		'{9'd511, 9'd511, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
		'{9'd511, 9'd511, 24'h0000FF, 1'b0, 24'h000000},
		'{9'd150, 9'd80,  24'h0080FF, 1'b0, 24'h000000},
		'{9'd150, 9'd80,  24'h00FF80, 1'b0, 24'h000000},
		'{9'd150, 9'd80,  24'h80FF00, 1'b0, 24'h000000},
		'{9'd150, 9'd80,  24'hFF8000, 1'b0, 24'h000000},
		'{9'd150, 9'd80,  24'hFF0080, 1'b0, 24'h000000},
		'{9'd150, 9'd80,  24'h8000FF, 1'b0, 24'h000000},
		'{9'd150, 9'd80,  24'h00FFFF, 1'b0, 24'h000000},
		'{9'd150, 9'd80,  24'hFFFF00, 1'b0, 24'h000000},
		'{9'd99,  9'd100, 24'h3C8CDC, 1'b0, 24'h000000},
		'{9'd100, 9'd101, 24'h3C8CDC, 1'b0, 24'h000000},
		'{9'd400, 9'd400, 24'h010203, 1'b0, 24'h000000},
		'{9'd0,   9'd0,   24'hFFFFFF, 1'b1, 24'h000000}
	};

	localparam logic [GAIN_W-1:0] PHASE_SAT [8] = '{9'd100, 9'd0, 9'd511, 9'd400, 9'd0,
		9'd511, 9'd150, 9'd37};
	localparam logic [GAIN_W-1:0] PHASE_VAL [8] = '{9'd100, 9'd0, 9'd511, 9'd400, 9'd511,
		9'd0, 9'd255, 9'd100};

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [DATA_W-1:0]   s_axis_tdata;   // red_in, green_in, blue_in
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [DATA_W-1:0]   m_axis_tdata;   // red_out, green_out, blue_out

	pending_t            expected_colors [$];
	logic [GAIN_W-1:0]   cur_sat_gain;
	logic [GAIN_W-1:0]   cur_val_gain;
	int                  mismatch_count;
	int                  cycle_count;
	int                  burst_left;
	bit                  rx_hold_req;

	hsv_saturation_value_gain_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int scale_pct(int comp, logic [GAIN_W-1:0] gain);
		int scaled;
		scaled = (comp * int'(gain)) / 100;
		return (scaled > 255) ? 255 : scaled;
	endfunction

	function automatic rgb_t adjust_color(rgb_t px, logic [GAIN_W-1:0] sat_gain,
			logic [GAIN_W-1:0] val_gain);
		int r, g, b, mx, mn, d, hue, sat, val, region, rem, p, q, t;
		rgb_t res;
		if (sat_gain == GAIN_UNITY && val_gain == GAIN_UNITY) begin
			return px;
		end
		r = int'(px.red);
		g = int'(px.green);
		b = int'(px.blue);
		mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
		mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
		d = mx - mn;
		val = mx;
		sat = 0;
		hue = 0;
		if (mx != 0) begin
			sat = (255 * d) / mx;
			if (sat != 0) begin
				if (mx == r) begin
					hue = 360 + (60 * (g - b)) / d;
					if (hue > 359) begin
						hue -= 360;
					end
				end else if (mx == g) begin
					hue = 120 + (60 * (b - r)) / d;
				end else begin
					hue = 240 + (60 * (r - g)) / d;
				end
			end
		end
		sat = scale_pct(sat, sat_gain);
		val = scale_pct(val, val_gain);
		if (sat == 0) begin
			res = '{blue: 8'(val), green: 8'(val), red: 8'(val)};
		end else begin
			region = hue / 60;
			rem = ((hue - region * 60) * 256) / 60;
			p = (val * (255 - sat)) >> 8;
			q = (val * (255 - ((sat * rem) >> 8))) >> 8;
			t = (val * (255 - ((sat * (255 - rem)) >> 8))) >> 8;
			case (region)
				SECT_0: res = '{blue: 8'(p), green: 8'(t), red: 8'(val)};
				SECT_1: res = '{blue: 8'(p), green: 8'(val), red: 8'(q)};
				SECT_2: res = '{blue: 8'(t), green: 8'(val), red: 8'(p)};
				SECT_3: res = '{blue: 8'(val), green: 8'(q), red: 8'(p)};
				SECT_4: res = '{blue: 8'(val), green: 8'(p), red: 8'(t)};
				default: res = '{blue: 8'(q), green: 8'(p), red: 8'(val)};
			endcase
		end
		return res;
	endfunction

	function automatic rgb_t random_color();
		int kind;
		logic [COMP_W-1:0] level;
		rgb_t px;
		kind = $urandom_range(0, 9);
		level = COMP_W'($urandom);
		px = rgb_t'(DATA_W'($urandom));
		case (kind)
			0: px = '{blue: level, green: level, red: level};
			1: px = '{blue: {8{px.blue[0]}}, green: {8{px.green[0]}}, red: {8{px.red[0]}}};
			2: px.green = px.red;
			3: px.blue = px.green;
			default: ;
		endcase
		return px;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < 40) begin
			$display("mismatch @%0t: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [COMP_W-1:0] got, logic [COMP_W-1:0] want,
			rgb_t px);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d want %0d for rgb %0d,%0d,%0d", name, got,
				want, px.red, px.green, px.blue));
		end
	endtask

	always @(posedge clk) begin
		pending_t head;
		rgb_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = rgb_t'(m_axis_tdata);
			if (expected_colors.size() == 0) begin
				report_mismatch($sformatf("unexpected word %06h", m_axis_tdata));
			end else begin
				head = expected_colors.pop_front();
				check_field("red", got.red, head.want.red, head.px);
				check_field("green", got.green, head.want.green, head.px);
				check_field("blue", got.blue, head.want.blue, head.px);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[hsv_saturation_value_gain_top] ERROR");
			$finish;
		end
	end

	initial begin
		int mode;
		int mode_left;
		int phase_tick;
		m_axis_tready = 1'b0;
		mode = 0;
		mode_left = 0;
		phase_tick = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				phase_tick++;
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					2: m_axis_tready <= ($urandom_range(0, 9) < 3);
					default: m_axis_tready <= phase_tick[2];
				endcase
			end
		end
	end

	// hold the word until accepted, then advance
	task automatic push_pixel(rgb_t px, logic known, rgb_t want);
		int gap;
		pending_t entry;
		s_axis_tdata <= px;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		entry.px = px;
		entry.want = known ? want : adjust_color(px, cur_sat_gain, cur_val_gain);
		expected_colors.push_back(entry);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (expected_colors.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [ADDR_W-1:0] addr, logic [GAIN_W-1:0] gain);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {23'($urandom), gain};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_gains(logic [GAIN_W-1:0] sat_gain, logic [GAIN_W-1:0] val_gain);
		drain();
		write_reg(SAT_GAIN_ADDR, sat_gain);
		write_reg(VAL_GAIN_ADDR, val_gain);
		cur_sat_gain = sat_gain;
		cur_val_gain = val_gain;
	endtask

	initial begin
		logic [GAIN_W-1:0] sat_gain;
		logic [GAIN_W-1:0] val_gain;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cur_sat_gain = GAIN_UNITY;
		cur_val_gain = GAIN_UNITY;
		mismatch_count = 0;
		cycle_count = 0;
		burst_left = 0;
		rx_hold_req = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED_VECTORS[i]) begin
			if (DIRECTED_VECTORS[i].sat_gain != cur_sat_gain ||
					DIRECTED_VECTORS[i].val_gain != cur_val_gain) begin
				set_gains(DIRECTED_VECTORS[i].sat_gain, DIRECTED_VECTORS[i].val_gain);
			end
			push_pixel(DIRECTED_VECTORS[i].px, DIRECTED_VECTORS[i].known,
				DIRECTED_VECTORS[i].want);
		end

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			if (ph < 8) begin
				sat_gain = PHASE_SAT[ph];
				val_gain = PHASE_VAL[ph];
			end else begin
				sat_gain = GAIN_W'($urandom_range(0, 511));
				val_gain = GAIN_W'($urandom_range(0, 511));
			end
			set_gains(sat_gain, val_gain);
			if (ph == 2) begin
				rx_hold_req = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 5 && n == 60) begin
					drain();
				end
				push_pixel(random_color(), 1'b0, '0);
			end
		end

		drain();
		repeat (NUM_STAGES + 4) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("[hsv_saturation_value_gain_top] OK");
		end else begin
			$display("[hsv_saturation_value_gain_top] ERROR");
		end
		$finish;
	end

endmodule

/* hsv_saturation_value_gain_top.f */
hdl/hsvg_pkg.sv
hdl/hsv_saturation_value_gain_top.sv
sim/tb_top.sv
